// ===== rtl/core/fdsl_pkg.sv =====
// Package for the field device status and LED sequencer.
// Holds the beat layouts, link status codes and tick constants.
// No dependencies; used by every module in rtl/core.
package fdsl_pkg;

  // Widths of the counters and fields.
  localparam int unsigned CountdownW = 17;
  localparam int unsigned TickCntW   = 6;
  localparam int unsigned PeriodW    = 16;
  localparam int unsigned LinkW      = 2;
  localparam int unsigned TdataW     = 8;

  // Tick constants for the button and the LED window.
  localparam logic [TickCntW-1:0] LedWindowTicks = TickCntW'(40);
  localparam logic [TickCntW-1:0] LongPressTicks = TickCntW'(40);

  // Smallest negative period that selects a fast rate.
  localparam logic signed [PeriodW-1:0] FastPeriodMin = -16'sd4;

  // Join states.
  localparam logic [1:0] JoinDiscovery = 2'd0;
  localparam logic [1:0] JoinJoined    = 2'd1;

  // Link status codes.
  localparam logic [LinkW-1:0] LinkNotOk    = 2'd0;
  localparam logic [LinkW-1:0] LinkOk       = 2'd1;
  localparam logic [LinkW-1:0] LinkDisabled = 2'd2;

  // Configuration register indexes.
  localparam logic CfgDaqEnable     = 1'b0;
  localparam logic CfgPublishPeriod = 1'b1;

  // One input beat, as held in the input register.
  typedef struct packed {
    logic       send_ok;
    logic       battery_ok;
    logic [1:0] join_state;
    logic       button_pressed;
  } in_item_t;

  // Acquisition outcome of one tick.
  typedef struct packed {
    logic             read_request;
    logic [LinkW-1:0] link_status;
  } acq_res_t;

  // Button and LED outcome of one tick.
  typedef struct packed {
    logic factory_reset;
    logic join_led;
    logic comm_led;
    logic battery_led;
  } panel_res_t;

endpackage

// ===== rtl/core/fdsl_acq.sv =====
// Acquisition scheduler: read countdown and link status for one tick.
// Depends on fdsl_pkg; instantiated by field_device_status_leds_top.
module fdsl_acq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             daq_enable_i,
  input  logic signed [fdsl_pkg::PeriodW-1:0] publish_period_i,
  input  logic                             send_ok_i,
  output fdsl_pkg::acq_res_t               acq_o
);
  import fdsl_pkg::*;

  logic [CountdownW-1:0] countdown_q, countdown_d;
  logic [LinkW-1:0]      comm_q, comm_d;
  logic [PeriodW-1:0]    neg_period;

  assign neg_period = PeriodW'(0) - publish_period_i;

  // Next countdown and link status from the current tick.
  always_comb begin
    countdown_d       = countdown_q;
    comm_d            = comm_q;
    acq_o.read_request = 1'b0;
    if (!daq_enable_i) begin
      comm_d = LinkDisabled;
    end else if (countdown_q != '0) begin
      countdown_d = countdown_q - CountdownW'(1);
    end else begin
      acq_o.read_request = 1'b1;
      if (send_ok_i) begin
        comm_d = LinkOk;
        if (publish_period_i[PeriodW-1]) begin
          if (publish_period_i >= FastPeriodMin) begin
            countdown_d = CountdownW'(neg_period);
          end
        end else begin
          countdown_d = {publish_period_i, 1'b0};
        end
      end else begin
        comm_d = LinkNotOk;
      end
    end
    acq_o.link_status = comm_d;
  end

  // State advances once per processed beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      countdown_q <= '0;
      comm_q      <= LinkNotOk;
    end else if (en_i) begin
      countdown_q <= countdown_d;
      comm_q      <= comm_d;
    end
  end

endmodule

// ===== rtl/core/fdsl_panel.sv =====
// Push button hold detection, LED window and the three status LEDs.
// Depends on fdsl_pkg; instantiated by field_device_status_leds_top.
module fdsl_panel (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  fdsl_pkg::in_item_t           item_i,
  input  logic [fdsl_pkg::LinkW-1:0]   link_status_i,
  output fdsl_pkg::panel_res_t         panel_o
);
  import fdsl_pkg::*;

  logic [TickCntW-1:0] hold_q, hold_d;
  logic [TickCntW-1:0] window_q, window_d;
  logic                join_q, comm_q, batt_q;
  logic                join_d, comm_d, batt_d;

  // Hold counter and LED window.
  always_comb begin
    hold_d                = hold_q;
    window_d              = window_q;
    panel_o.factory_reset = 1'b0;
    if (item_i.button_pressed) begin
      if (hold_q < LongPressTicks) begin
        hold_d = hold_q + TickCntW'(1);
      end else begin
        panel_o.factory_reset = 1'b1;
        hold_d                = '0;
      end
      window_d = LedWindowTicks;
    end else begin
      hold_d = '0;
      if (window_q != '0) begin
        window_d = window_q - TickCntW'(1);
      end
    end
  end

  // LED drive: solid, blinking or off inside the window, off outside it.
  always_comb begin
    join_d = join_q;
    comm_d = comm_q;
    batt_d = batt_q;
    if (window_d != '0) begin
      if (item_i.join_state == JoinJoined) begin
        join_d = 1'b1;
      end else if (item_i.join_state == JoinDiscovery) begin
        if (window_d[2:0] == 3'd0) join_d = ~join_q;
      end else if (!window_d[0]) begin
        join_d = ~join_q;
      end

      if (link_status_i == LinkOk) begin
        comm_d = 1'b1;
      end else if (link_status_i == LinkNotOk) begin
        if (!window_d[0]) comm_d = ~comm_q;
      end else begin
        comm_d = 1'b0;
      end

      if (item_i.battery_ok) begin
        batt_d = 1'b1;
      end else if (window_d[1:0] == 2'd0) begin
        batt_d = ~batt_q;
      end
    end else begin
      join_d = 1'b0;
      comm_d = 1'b0;
      batt_d = 1'b0;
    end
    panel_o.join_led    = join_d;
    panel_o.comm_led    = comm_d;
    panel_o.battery_led = batt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q   <= '0;
      window_q <= '0;
      join_q   <= 1'b0;
      comm_q   <= 1'b0;
      batt_q   <= 1'b0;
    end else if (en_i) begin
      hold_q   <= hold_d;
      window_q <= window_d;
      join_q   <= join_d;
      comm_q   <= comm_d;
      batt_q   <= batt_d;
    end
  end

endmodule

// ===== rtl/core/field_device_status_leds_top.sv =====
// Field device status and LED sequencer, one input beat per 250 ms tick.
// Path: an accepted beat is held in the input register, then its result in the
// result register. Throughput: one beat per cycle,
// held back only when the result register is full and not being taken.
// Reset (rst_ni low, asynchronous) clears both registers, the countdown,
// link status (not ok), hold count, LED window and LEDs; configuration is 0.
module field_device_status_leds_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_index_i,
  input  logic [fdsl_pkg::PeriodW-1:0]   cfg_data_i,
  // Tick input stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: button_pressed, join_state[1:0], battery_ok, send_ok, zero fill
  input  logic [fdsl_pkg::TdataW-1:0]    s_axis_tdata,
  // Result stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: read_request, factory_reset, join_led, comm_led, battery_led,
  //        link_status[1:0], zero fill
  output logic [fdsl_pkg::TdataW-1:0]    m_axis_tdata
);
  import fdsl_pkg::*;

  logic                       daq_enable_q;
  logic signed [PeriodW-1:0]  period_q;
  logic                       in_valid_q, out_valid_q;
  in_item_t                   in_q;
  logic [TdataW-1:0]          out_q, out_d;
  logic                       advance;
  acq_res_t                   acq;
  panel_res_t                 panel;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      daq_enable_q <= 1'b0;
      period_q     <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgDaqEnable:     daq_enable_q <= cfg_data_i[0];
        CfgPublishPeriod: period_q     <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  // A beat leaves the input register when the result register can take it.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= in_item_t'(s_axis_tdata[4:0]);
    end
  end

  fdsl_acq u_acq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (advance),
    .daq_enable_i     (daq_enable_q),
    .publish_period_i (period_q),
    .send_ok_i        (in_q.send_ok),
    .acq_o            (acq)
  );

  fdsl_panel u_panel (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .item_i        (in_q),
    .link_status_i (acq.link_status),
    .panel_o       (panel)
  );

  // Result beat packing.
  assign out_d = {1'b0, acq.link_status, panel.battery_led, panel.comm_led,
                  panel.join_led, panel.factory_reset, acq.read_request};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // A read request is never reported with the link disabled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[6:5] != LinkDisabled)
    else $error("read request reported while link disabled");

  // Input side stalls only with both registers full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready)
    else $error("input stalled without a full pipeline");

  // A processed beat with acquisition off reports the link disabled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !daq_enable_q |=> out_q[6:5] == LinkDisabled && out_valid_q)
    else $error("link status not disabled with acquisition off");

  // A factory reset pulse only comes from a pressed tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && panel.factory_reset |-> in_q.button_pressed)
    else $error("factory reset without button press");

endmodule

// ===== verif/field_device_status_leds_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for field_device_status_leds_top: tick beats in, status beats out.
// Every status beat is predicted by a local model of the sequencer and checked field by field.
// Depends on fdsl_pkg and the RTL in rtl/core; nothing else is read.
module field_device_status_leds_top_tb;
  import fdsl_pkg::*;

  // Tick counts of the button and LED logic, as the block is specified.
  localparam int unsigned WindowTicks     = 40;
  localparam int unsigned HoldTicks       = 40;
  // Long output hold-off used to fill the block and stall its input.
  localparam int unsigned LongStallCycles = 300;
  // Number of configuration settings swept by the random part.
  localparam int unsigned NumSettings     = 12;

  // One status beat, highest bit first as it travels in m_axis_tdata.
  typedef struct packed {
    logic [1:0] link_status;
    logic       battery_led;
    logic       comm_led;
    logic       join_led;
    logic       factory_reset;
    logic       read_request;
  } tick_outcome_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic                 cfg_index_i   = CfgDaqEnable;
  logic [PeriodW-1:0]   cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TdataW-1:0]    s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TdataW-1:0]    m_axis_tdata;

  // Local copy of the configuration and the sequencer state.
  logic                 acq_on;
  logic signed [15:0]   period_cfg;
  logic [16:0]          sched_count;
  logic [1:0]           link_now;
  logic [5:0]           hold_ticks;
  logic [5:0]           window_ticks;
  logic                 join_lamp;
  logic                 comm_lamp;
  logic                 batt_lamp;

  tick_outcome_t        pending_outcomes[$];
  tick_outcome_t        got_outcome;
  tick_outcome_t        want_outcome;

  int unsigned          fail_count     = 0;
  int unsigned          bad_beats      = 0;
  int unsigned          ticks_sent     = 0;
  int unsigned          beats_checked  = 0;
  int unsigned          reads_expected = 0;
  int unsigned          resets_expected = 0;
  int unsigned          tx_idle_pct    = 0;
  int unsigned          rx_stall_pct   = 0;
  int unsigned          hold_seq       = 0;
  int unsigned          hold_seen      = 0;
  int unsigned          hold_left      = 0;

  field_device_status_leds_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Free-running clock, 20 ns period.
  always #10 clk_i = ~clk_i;

  // Advances the local model by one tick and returns the status it should show.
  function automatic tick_outcome_t predict_tick(input in_item_t it);
    tick_outcome_t res;
    int            p;
    res = '0;
    p   = period_cfg;

    // Acquisition scheduling comes first.
    if (acq_on) begin
      if (sched_count != 0) begin
        sched_count = sched_count - 1'b1;
      end else begin
        res.read_request = 1'b1;
        if (it.send_ok) begin
          if (p < 0) begin
            if (p >= -4) sched_count = 17'(-p);
          end else begin
            sched_count = 17'(2 * p);
          end
          link_now = LinkOk;
        end else begin
          link_now = LinkNotOk;
        end
      end
    end else begin
      link_now = LinkDisabled;
    end

    // Button: long hold and LED window.
    if (it.button_pressed) begin
      if (hold_ticks < HoldTicks) begin
        hold_ticks = hold_ticks + 1'b1;
      end else begin
        res.factory_reset = 1'b1;
        hold_ticks        = '0;
      end
      window_ticks = 6'(WindowTicks);
    end else begin
      hold_ticks = '0;
      if (window_ticks != 0) window_ticks = window_ticks - 1'b1;
    end

    // LEDs, solid, blinking or off while the window is open.
    if (window_ticks != 0) begin
      if (it.join_state == JoinJoined) begin
        join_lamp = 1'b1;
      end else if (it.join_state == JoinDiscovery) begin
        if (window_ticks[2:0] == 3'd0) join_lamp = ~join_lamp;
      end else if (!window_ticks[0]) begin
        join_lamp = ~join_lamp;
      end

      if (link_now == LinkOk) begin
        comm_lamp = 1'b1;
      end else if (link_now == LinkNotOk) begin
        if (!window_ticks[0]) comm_lamp = ~comm_lamp;
      end else begin
        comm_lamp = 1'b0;
      end

      if (it.battery_ok) begin
        batt_lamp = 1'b1;
      end else if (window_ticks[1:0] == 2'd0) begin
        batt_lamp = ~batt_lamp;
      end
    end else begin
      join_lamp = 1'b0;
      comm_lamp = 1'b0;
      batt_lamp = 1'b0;
    end

    res.join_led    = join_lamp;
    res.comm_led    = comm_lamp;
    res.battery_led = batt_lamp;
    res.link_status = link_now;
    return res;
  endfunction

  function automatic in_item_t tick_in(input logic btn, input logic [1:0] join_st,
                                       input logic batt, input logic sent);
    in_item_t it;
    it.button_pressed = btn;
    it.join_state     = join_st;
    it.battery_ok     = batt;
    it.send_ok        = sent;
    return it;
  endfunction

  // Offers one tick beat, with random idle cycles before it, and records its outcome.
  task automatic send_tick(input in_item_t it);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, it};
    do @(posedge clk_i); while (!s_axis_tready);
    want_outcome = predict_tick(it);
    pending_outcomes.push_back(want_outcome);
    ticks_sent++;
    reads_expected  += want_outcome.read_request;
    resets_expected += want_outcome.factory_reset;
  endtask

  // Stops offering ticks and waits until every status beat has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes one configuration register; only called with the block drained.
  task automatic write_reg(input logic idx, input logic [PeriodW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgDaqEnable) acq_on = value[0];
    else period_cfg = value;
  endtask

  task automatic apply_settings(input logic en, input logic [PeriodW-1:0] period);
    logic [PeriodW-1:0] word;
    wait_drained();
    write_reg(CfgPublishPeriod, period);
    // The upper bits of the enable word carry noise; only bit 0 counts.
    word    = 16'($urandom());
    word[0] = en;
    write_reg(CfgDaqEnable, word);
  endtask

  // Random ticks shaped as button presses of varied length followed by releases.
  task automatic send_random_ticks(input int unsigned n);
    int unsigned left;
    int unsigned press_len;
    int unsigned release_len;
    int unsigned sel;
    int unsigned k;
    logic [1:0]  join_st;
    logic        batt;
    in_item_t    it;
    left = n;
    while (left > 0) begin
      sel = $urandom_range(99);
      if (sel < 25)      press_len = 0;
      else if (sel < 55) press_len = $urandom_range(10, 1);
      else if (sel < 85) press_len = $urandom_range(44, 38);
      else               press_len = $urandom_range(90, 45);
      release_len = $urandom_range(48, 0);
      join_st     = 2'($urandom_range(3));
      batt        = ($urandom_range(99) < 60);
      for (k = 0; k < press_len + release_len && left > 0; k++) begin
        // The join state and battery occasionally move inside a window.
        if ($urandom_range(99) < 8) join_st = 2'($urandom_range(3));
        if ($urandom_range(99) < 4) batt = ~batt;
        it = tick_in(k < press_len, join_st, batt, $urandom_range(99) < 75);
        if ($urandom_range(99) < 5) it = in_item_t'(5'($urandom_range(31)));
        send_tick(it);
        left--;
      end
    end
  endtask

  // Field extremes, every join state and the request corner cases.
  task automatic test_directed_ticks();
    rx_stall_pct = 0;
    tx_idle_pct  = 0;
    apply_settings(1'b1, -16'sd1);
    send_tick(tick_in(1'b0, 2'd0, 1'b0, 1'b0));  // request refused: link not ok
    send_tick(tick_in(1'b0, 2'd0, 1'b0, 1'b1));  // request accepted, short reload
    send_tick(tick_in(1'b0, 2'd1, 1'b1, 1'b1));  // send_ok with no request pending
    send_tick(tick_in(1'b0, 2'd2, 1'b0, 1'b0));
    send_tick(tick_in(1'b1, 2'd0, 1'b0, 1'b1));  // window opens in discovery
    send_tick(tick_in(1'b1, 2'd1, 1'b1, 1'b0));
    send_tick(tick_in(1'b0, 2'd2, 1'b0, 1'b1));
    send_tick(tick_in(1'b0, 2'd3, 1'b0, 1'b0));
    send_tick(tick_in(1'b1, 2'd3, 1'b1, 1'b1));  // every input bit high
    // A period below the fast range leaves the countdown at zero.
    apply_settings(1'b1, -16'sd5);
    send_tick(tick_in(1'b1, 2'd0, 1'b0, 1'b1));
    send_tick(tick_in(1'b0, 2'd0, 1'b0, 1'b1));
    send_tick(tick_in(1'b0, 2'd1, 1'b0, 1'b0));
    send_tick(tick_in(1'b0, 2'd2, 1'b1, 1'b1));
    send_tick(tick_in(1'b0, 2'd3, 1'b0, 1'b0));
    // Acquisition switched off: link reads disabled.
    apply_settings(1'b0, 16'sd0);
    send_tick(tick_in(1'b1, 2'd2, 1'b0, 1'b1));
    send_tick(tick_in(1'b0, 2'd1, 1'b1, 1'b0));
    send_tick(tick_in(1'b0, 2'd0, 1'b0, 1'b1));
    send_tick(tick_in(1'b0, 2'd0, 1'b0, 1'b0));
    send_tick(tick_in(1'b0, 2'd0, 1'b1, 1'b0));
  endtask

  // Output held off for a long stretch while ticks keep coming, then a full drain and ten more ticks.
  task automatic test_output_stall();
    apply_settings(1'b1, 16'sd2);
    rx_stall_pct = 0;
    tx_idle_pct  = 0;
    hold_seq++;
    send_random_ticks(40);
    wait_drained();
    send_random_ticks(10);
  endtask

  // Sweeps the publishing settings, cycling through four idling patterns.
  task automatic test_publish_settings();
    logic              set_en[NumSettings];
    logic signed [15:0] set_period[NumSettings];
    int unsigned       mid_period;
    int unsigned       s;
    mid_period = $urandom_range(12, 2);
    set_en     = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    set_period = '{16'sd0, 16'sd0, 16'sd1, -16'sd1, -16'sd4, -16'sd5, -16'sd32768,
                   16'(mid_period), 16'(mid_period), 16'(mid_period), -16'sd2,
                   16'sd32767};
    for (s = 0; s < NumSettings; s++) begin
      apply_settings(set_en[s], set_period[s]);
      case (s % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 59; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 59; end
        default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
      endcase
      send_random_ticks(152);
    end
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
  endtask

  // Output side: random stalls, plus a long hold-off whenever one is asked for.
  always @(posedge clk_i) begin
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = LongStallCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got, inout logic bad);
    if (want != got) begin
      bad = 1'b1;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Checks every status beat against the oldest outstanding prediction.
  always @(posedge clk_i) begin : check_outcomes
    logic bad;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_outcome = tick_outcome_t'(m_axis_tdata[6:0]);
      if (pending_outcomes.size() == 0) begin
        fail_count++;
        $error("status beat 0x%02h arrived with no tick outstanding", m_axis_tdata);
      end else begin
        want_outcome = pending_outcomes.pop_front();
        bad = 1'b0;
        compare_field("read_request", want_outcome.read_request,
                      got_outcome.read_request, bad);
        compare_field("factory_reset", want_outcome.factory_reset,
                      got_outcome.factory_reset, bad);
        compare_field("join_led", want_outcome.join_led, got_outcome.join_led, bad);
        compare_field("comm_led", want_outcome.comm_led, got_outcome.comm_led, bad);
        compare_field("battery_led", want_outcome.battery_led,
                      got_outcome.battery_led, bad);
        compare_field("link_status", want_outcome.link_status,
                      got_outcome.link_status, bad);
        if (bad) begin
          fail_count++;
          bad_beats++;
        end
        beats_checked++;
      end
    end
  end

  // Main sequence: reset once, run the tests, drain and report.
  initial begin : main_seq
    int unsigned guard;
    acq_on       = 1'b0;
    period_cfg   = '0;
    sched_count  = '0;
    link_now     = LinkNotOk;
    hold_ticks   = '0;
    window_ticks = '0;
    join_lamp    = 1'b0;
    comm_lamp    = 1'b0;
    batt_lamp    = 1'b0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_ticks();
    test_output_stall();
    test_publish_settings();

    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (pending_outcomes.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_outcomes.size() != 0) begin
      fail_count += pending_outcomes.size();
      $error("%0d status beats never arrived", pending_outcomes.size());
    end

    $display("Ran %0d ticks over %0d publishing settings; %0d status beats checked.",
             ticks_sent, NumSettings + 4, beats_checked);
    $display("Predicted %0d read requests and %0d factory resets; %0d beats failed.",
             reads_expected, resets_expected, bad_beats);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/fdsl_pkg.sv
rtl/core/fdsl_acq.sv
rtl/core/fdsl_panel.sv
rtl/core/field_device_status_leds_top.sv
verif/field_device_status_leds_top_tb.sv
